@@ rtl/scld_pkg.sv @@
// ----------------------------------------------------------------------------
// scld_pkg: shared types and constants for the serial command line decoder
// Line state record, result record, command codes and keyword tables.
// ----------------------------------------------------------------------------
package scld_pkg;

    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_PLUS  = 8'h2B;
    localparam logic [7:0] BYTE_MINUS = 8'h2D;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;

    localparam int KW_COUNT = 3;
    localparam logic [6:0] VOLUME_MAX = 7'd100;
    localparam logic [6:0] VALUE_SAT  = 7'd127;
    localparam logic [3:0] POS_SAT    = 4'd15;

    typedef enum logic [2:0] {
        CMD_TOGGLE     = 3'd0,
        CMD_NEXT       = 3'd1,
        CMD_PREV       = 3'd2,
        CMD_VOLUME     = 3'd3,
        CMD_INVALID    = 3'd4
    } t_cmd;

    // keyword text, padded to 16 places; lengths guard the padding
    localparam logic [7:0] KW_TEXT [KW_COUNT][16] = '{
        '{8'h70, 8'h6C, 8'h61, 8'h79, 8'h5F, 8'h70, 8'h61, 8'h75,
          8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6E, 8'h65, 8'h78, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h70, 8'h72, 8'h65, 8'h76, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd10, 4'd4, 4'd4};

    typedef struct packed {
        logic       newline_pending;
        logic       content_seen;
        logic       space_after_content;
        logic       line_broken;
        logic [3:0] keyword_position;
        logic [2:0] keyword_candidates;
        logic       number_candidate;
        logic       sign_seen;
        logic       negative_sign;
        logic       digit_seen;
        logic [6:0] number_value;
    } t_line_state;

    localparam t_line_state LINE_RESET = '{
        newline_pending:     1'b0,
        content_seen:        1'b0,
        space_after_content: 1'b0,
        line_broken:         1'b0,
        keyword_position:    4'd0,
        keyword_candidates:  3'b111,
        number_candidate:    1'b1,
        sign_seen:           1'b0,
        negative_sign:       1'b0,
        digit_seen:          1'b0,
        number_value:        7'd0
    };

    typedef struct packed {
        logic       fire;
        t_cmd       command;
        logic [6:0] volume;
    } t_result;

endpackage

@@ rtl/scld_step.sv @@
// ----------------------------------------------------------------------------
// scld_step: per-byte line state update
// Folds one byte into the line state and forms the result at a line end.
// ----------------------------------------------------------------------------
module scld_step (
    input  scld_pkg::t_line_state i_state,
    input  logic [7:0]            i_byte,
    output scld_pkg::t_line_state o_state,
    output scld_pkg::t_result     o_result
);

    logic        w_space;
    logic        w_digit;
    logic [10:0] w_value;
    logic [3:0]  w_pos;
    scld_pkg::t_line_state n_state;
    scld_pkg::t_result     w_result;

    assign w_space = (i_byte == scld_pkg::BYTE_SPACE) ||
                     (i_byte >= scld_pkg::BYTE_TAB && i_byte <= scld_pkg::BYTE_CR);
    assign w_digit = (i_byte >= scld_pkg::BYTE_ZERO) && (i_byte <= scld_pkg::BYTE_NINE);
    assign w_value = {4'd0, i_state.number_value} * 11'd10 + {7'd0, i_byte[3:0]};
    assign w_pos   = i_state.keyword_position;

    // end-of-line verdict from the current state
    always_comb begin
        w_result.fire    = 1'b1;
        w_result.command = scld_pkg::CMD_INVALID;
        w_result.volume  = 7'd0;
        if (i_state.content_seen && !i_state.line_broken) begin
            priority if (i_state.keyword_candidates[0] && w_pos == scld_pkg::KW_LEN[0]) begin
                w_result.command = scld_pkg::CMD_TOGGLE;
            end else if (i_state.keyword_candidates[1] && w_pos == scld_pkg::KW_LEN[1]) begin
                w_result.command = scld_pkg::CMD_NEXT;
            end else if (i_state.keyword_candidates[2] && w_pos == scld_pkg::KW_LEN[2]) begin
                w_result.command = scld_pkg::CMD_PREV;
            end else if (i_state.number_candidate && i_state.digit_seen &&
                         i_state.number_value <= scld_pkg::VOLUME_MAX &&
                         (!i_state.negative_sign || i_state.number_value == 7'd0)) begin
                w_result.command = scld_pkg::CMD_VOLUME;
                w_result.volume  = i_state.number_value;
            end else begin
                w_result.command = scld_pkg::CMD_INVALID;
            end
        end
    end

    always_comb begin
        n_state  = i_state;
        o_result = '{fire: 1'b0, command: scld_pkg::CMD_INVALID, volume: 7'd0};
        if (i_state.newline_pending && i_byte == scld_pkg::BYTE_CR) begin
            o_result = w_result;
            n_state  = scld_pkg::LINE_RESET;
        end else begin
            // a newline not followed by CR is plain whitespace
            if (i_state.newline_pending) begin
                n_state.newline_pending = 1'b0;
                if (n_state.content_seen) begin
                    n_state.space_after_content = 1'b1;
                end
            end
            if (i_byte == scld_pkg::BYTE_LF) begin
                n_state.newline_pending = 1'b1;
            end else if (w_space) begin
                if (n_state.content_seen) begin
                    n_state.space_after_content = 1'b1;
                end
            end else begin
                if (n_state.space_after_content) begin
                    n_state.line_broken = 1'b1;
                end
                n_state.content_seen = 1'b1;
                for (int k = 0; k < scld_pkg::KW_COUNT; k++) begin
                    if (w_pos >= scld_pkg::KW_LEN[k] ||
                        scld_pkg::KW_TEXT[k][w_pos] != i_byte) begin
                        n_state.keyword_candidates[k] = 1'b0;
                    end
                end
                priority if (w_pos == 4'd0 &&
                             (i_byte == scld_pkg::BYTE_PLUS ||
                              i_byte == scld_pkg::BYTE_MINUS)) begin
                    n_state.sign_seen     = 1'b1;
                    n_state.negative_sign = (i_byte == scld_pkg::BYTE_MINUS);
                end else if (w_digit) begin
                    n_state.digit_seen   = 1'b1;
                    n_state.number_value = (w_value > {4'd0, scld_pkg::VALUE_SAT}) ?
                                           scld_pkg::VALUE_SAT : w_value[6:0];
                end else begin
                    n_state.number_candidate = 1'b0;
                end
                if (w_pos < scld_pkg::POS_SAT) begin
                    n_state.keyword_position = w_pos + 4'd1;
                end
            end
        end
    end

    assign o_state = n_state;

endmodule

@@ rtl/serial_command_line_decoder_core.sv @@
// ----------------------------------------------------------------------------
// serial_command_line_decoder_core: serial command line decoder
// Cuts a byte stream into LF-CR terminated lines and decodes each line.
// ----------------------------------------------------------------------------
// Path: a line-ending CR is accepted into the input register, then decoded into
//   the result register, whose valid flag drives o_valid.
// Throughput: one word per cycle unless a line end stalls; the state update is one pass of logic
//   between the input register and the line state / result registers.
// Stall: only a line-ending byte waits, and only while a held result is stalled.
// Reset: synchronous, active low; clears both registers' valid flags and the
//   line state.
// ----------------------------------------------------------------------------
module serial_command_line_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_command,
    output logic [6:0] o_volume
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // line state, held between words
    scld_pkg::t_line_state r_state;
    scld_pkg::t_line_state w_next_state;
    scld_pkg::t_result     w_result;

    // result register
    logic          r_out_valid;
    scld_pkg::t_cmd r_command;
    logic [6:0]    r_volume;

    logic w_advance;
    logic w_in_take;
    logic w_out_take;

    scld_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (w_next_state),
        .o_result (w_result)
    );

    // A word that ends a line needs a free result slot; every other word
    // passes straight through the state update.
    assign w_out_take = r_out_valid && !i_stall;
    assign w_advance  = !(w_result.fire && r_out_valid && i_stall);
    assign o_stall    = r_in_valid && !w_advance;
    assign w_in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= scld_pkg::LINE_RESET;
        end else begin
            if (!r_in_valid || w_advance) begin
                r_in_valid <= w_in_take;
            end
            if (r_in_valid && w_advance) begin
                r_state <= w_next_state;
            end
            if (r_in_valid && w_advance && w_result.fire) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_rx_byte;
        end
        if (r_in_valid && w_advance && w_result.fire) begin
            r_command <= w_result.command;
            r_volume  <= w_result.volume;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_command = r_command;
    assign o_volume  = r_volume;

    // a stall toward the sender only comes from a held, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked result");

    // volume is zero unless a volume command is shown, and never above max
    a_volume_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_command == scld_pkg::CMD_VOLUME) ?
                         (r_volume <= scld_pkg::VOLUME_MAX) : (r_volume == 7'd0)))
        else $error("volume out of range for command");

    // content count and content flag move together
    a_content_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.content_seen == (r_state.keyword_position != 4'd0))
        else $error("content flag and keyword position disagree");

    // a broken line has had content
    a_broken_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.line_broken |-> r_state.content_seen)
        else $error("line broken without content");

    // a line-ending word leaves the line state at its reset value
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_advance && w_result.fire) |=> (r_state == scld_pkg::LINE_RESET))
        else $error("line state not cleared after line end");

endmodule
